/* sv/rlcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcc_pkg: shared types and constants of the RGB565 line color classifier
// Holds field widths, register reset values, register indexes, color codes,
// the threshold and queue entry structs and the saturating count helper.
// ----------------------------------------------------------------------------
package rlcc_pkg;

	// Field widths.
	localparam int RED_W   = 8;
	localparam int GREEN_W = 6;
	localparam int BLUE_W  = 5;
	localparam int HITS_W  = 10;
	localparam int LIM_W   = 12;
	localparam int PERS_W  = 13;
	localparam int SPEED_W = 11;
	localparam int COLOR_W = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// Defaults for the top level parameters.
	localparam int DEF_LINE_PIXELS = 640;
	localparam int DEF_FULL_SPEED  = 1100;
	localparam int DEF_QUEUE_DEPTH = 2;

	// Register reset values.
	localparam logic [RED_W-1:0]   RST_RED_MIN       = 8'd120;
	localparam logic [GREEN_W-1:0] RST_RED_GREEN_MAX = 6'd16;
	localparam logic [GREEN_W-1:0] RST_GREEN_MIN     = 6'd21;
	localparam logic [RED_W-1:0]   RST_GREEN_RED_MAX = 8'd65;
	localparam logic [BLUE_W-1:0]  RST_BLUE_MIN      = 5'd13;
	localparam logic [RED_W-1:0]   RST_BLUE_RED_MAX  = 8'd70;
	localparam logic [HITS_W-1:0]  RST_LINE_HITS_MIN = 10'd150;
	localparam logic [LIM_W-1:0]   RST_PERSIST_LIMIT = 12'd4000;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RED_MIN       = 3'd0,
		REG_RED_GREEN_MAX = 3'd1,
		REG_GREEN_MIN     = 3'd2,
		REG_GREEN_RED_MAX = 3'd3,
		REG_BLUE_MIN      = 3'd4,
		REG_BLUE_RED_MAX  = 3'd5,
		REG_LINE_HITS_MIN = 3'd6,
		REG_PERSIST_LIMIT = 3'd7
	} reg_idx_t;

	// Line class codes.
	typedef enum logic [COLOR_W-1:0] {
		COLOR_NONE  = 2'd0,
		COLOR_RED   = 2'd1,
		COLOR_GREEN = 2'd2,
		COLOR_BLUE  = 2'd3
	} color_t;

	// Per-pixel thresholds used by the front end.
	typedef struct packed {
		logic [RED_W-1:0]   red_min;
		logic [GREEN_W-1:0] red_green_max;
		logic [GREEN_W-1:0] green_min;
		logic [RED_W-1:0]   green_red_max;
		logic [BLUE_W-1:0]  blue_min;
		logic [RED_W-1:0]   blue_red_max;
	} pix_thr_t;

	// Per-line thresholds used by the back end.
	typedef struct packed {
		logic [HITS_W-1:0] line_hits_min;
		logic [LIM_W-1:0]  persist_limit;
	} line_thr_t;

	// Hit totals of one finished line, as queued between front and back.
	typedef struct packed {
		logic [HITS_W-1:0] red_hits;
		logic [HITS_W-1:0] green_hits;
		logic [HITS_W-1:0] blue_hits;
	} line_hits_t;

	// Count up by one, holding at the top value.
	function automatic logic [HITS_W-1:0] sat_bump(input logic [HITS_W-1:0] c);
		logic [HITS_W-1:0] r;
		r = (c == {HITS_W{1'b1}}) ? c : c + 1'b1;
		return r;
	endfunction

endpackage

/* sv/rlcc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcc_front: pixel front end
// Unpacks each RGB565 pixel, counts red, green and blue hits over the line and
// hands the line totals to the line queue on the last pixel of the line.
// ----------------------------------------------------------------------------
module rlcc_front
	import rlcc_pkg::*;
#(
	parameter int LINE_PIXELS = DEF_LINE_PIXELS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pix_thr_t         thr,
	input  logic             pix_valid,
	input  logic [7:0]       pix_hi,
	input  logic [7:0]       pix_lo,
	input  logic             pix_last,
	output logic             pix_ready,
	input  logic             q_full,
	output logic             q_push,
	output line_hits_t       q_data
);

	localparam int CNT_W = $clog2(LINE_PIXELS + 1);
	localparam logic [CNT_W-1:0] LINE_LEN = CNT_W'(LINE_PIXELS);

	logic [HITS_W-1:0] red_hits_q, green_hits_q, blue_hits_q;
	logic [HITS_W-1:0] red_nxt, green_nxt, blue_nxt;
	logic [CNT_W-1:0]  pix_cnt_q, pix_cnt_nxt;
	logic [RED_W-1:0]   r;
	logic [GREEN_W-1:0] g;
	logic [BLUE_W-1:0]  b;
	logic fire, line_done;

	// A pixel transfer is taken whenever the queue has room for a line.
	assign pix_ready = !q_full;
	assign fire      = pix_valid && pix_ready;

	// Unpack the pixel.
	assign r = {pix_hi[7:3], 3'b000};
	assign g = {pix_hi[2:0], pix_lo[7:5]};
	assign b = pix_lo[4:0];

	// Hit tests and the next hit counts.
	always_comb begin
		red_nxt   = red_hits_q;
		green_nxt = green_hits_q;
		blue_nxt  = blue_hits_q;
		if (r > thr.red_min && g < thr.red_green_max) begin
			red_nxt = sat_bump(red_hits_q);
		end
		if (g > thr.green_min && r < thr.green_red_max) begin
			green_nxt = sat_bump(green_hits_q);
		end
		if (b > thr.blue_min && r < thr.blue_red_max) begin
			blue_nxt = sat_bump(blue_hits_q);
		end
	end

	// The line ends on its marked last pixel or on an overlong line.
	assign pix_cnt_nxt = pix_cnt_q + 1'b1;
	assign line_done   = pix_last || (pix_cnt_nxt >= LINE_LEN);

	assign q_push            = fire && line_done;
	assign q_data.red_hits   = red_nxt;
	assign q_data.green_hits = green_nxt;
	assign q_data.blue_hits  = blue_nxt;

	// Line counters, cleared when the totals go to the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_hits_q   <= '0;
			green_hits_q <= '0;
			blue_hits_q  <= '0;
			pix_cnt_q    <= '0;
		end else if (fire) begin
			if (line_done) begin
				red_hits_q   <= '0;
				green_hits_q <= '0;
				blue_hits_q  <= '0;
				pix_cnt_q    <= '0;
			end else begin
				red_hits_q   <= red_nxt;
				green_hits_q <= green_nxt;
				blue_hits_q  <= blue_nxt;
				pix_cnt_q    <= pix_cnt_nxt;
			end
		end
	end

	// The pixel count never reaches the line length between lines.
	assert property (@(posedge clk) disable iff (!arst_n) pix_cnt_q < LINE_LEN)
		else $error("rlcc_front: pixel count reached the line length");

	// A line handed to the queue leaves all counters clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> (red_hits_q == '0 && green_hits_q == '0 &&
			blue_hits_q == '0 && pix_cnt_q == '0))
		else $error("rlcc_front: counters not cleared after line end");

	// Nothing is pushed into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_full |-> !q_push)
		else $error("rlcc_front: push into a full queue");

endmodule

/* sv/rlcc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcc_queue: line queue
// Small first-in first-out store of line hit totals between the front end
// and the back end, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module rlcc_queue
	import rlcc_pkg::*;
#(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  line_hits_t push_data,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output line_hits_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

	line_hits_t        entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == DEPTH_C);
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// The fill count stays within the depth.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= DEPTH_C)
		else $error("rlcc_queue: fill count beyond depth");

	// No pop from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("rlcc_queue: pop from an empty queue");

	// Pointers agree when the queue is empty.
	assert property (@(posedge clk) disable iff (!arst_n) empty |-> wr_ptr_q == rd_ptr_q)
		else $error("rlcc_queue: pointers differ while empty");

endmodule

/* sv/rlcc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcc_back: line decision back end
// Classifies each queued line, keeps green persistence, the red latch and
// the speed reduction, and holds the result in an output register.
// ----------------------------------------------------------------------------
module rlcc_back
	import rlcc_pkg::*;
#(
	parameter int FULL_SPEED = DEF_FULL_SPEED
) (
	input  logic               clk,
	input  logic               arst_n,
	input  line_thr_t          thr,
	input  logic               q_empty,
	input  line_hits_t         q_data,
	output logic               q_pop,
	output logic               res_valid,
	input  logic               res_ready,
	output color_t             res_color,
	output logic [SPEED_W-1:0] res_speed
);

	localparam logic [SPEED_W-1:0] SPEED_FULL = SPEED_W'(FULL_SPEED);
	localparam logic [SPEED_W-1:0] SPEED_HALF = SPEED_W'(FULL_SPEED / 2);

	logic [PERS_W-1:0]  persist_q, persist_nxt, persist_inc;
	logic               latch_q, latch_nxt;
	logic [SPEED_W-1:0] speed_q, speed_nxt;
	logic               res_valid_q;
	color_t             color_q, color_nxt;

	// A line is taken when the output register is free or being emptied.
	assign q_pop = !q_empty && (!res_valid_q || res_ready);

	assign persist_inc = persist_q + 1'b1;

	// Line class and persistence.
	always_comb begin
		persist_nxt = persist_q;
		color_nxt   = COLOR_NONE;
		if (q_data.red_hits > thr.line_hits_min) begin
			color_nxt = COLOR_RED;
		end else if (q_data.green_hits > thr.line_hits_min) begin
			if (persist_inc > {1'b0, thr.persist_limit}) begin
				persist_nxt = '0;
				color_nxt   = COLOR_GREEN;
			end else begin
				persist_nxt = persist_inc;
			end
		end else if (q_data.blue_hits > thr.line_hits_min) begin
			color_nxt = COLOR_BLUE;
		end else begin
			persist_nxt = '0;
		end
	end

	// Red latch and speed reduction.
	always_comb begin
		latch_nxt = latch_q;
		speed_nxt = speed_q;
		case (color_nxt)
			COLOR_RED: begin
				latch_nxt = 1'b1;
				speed_nxt = SPEED_FULL;
			end
			COLOR_GREEN: begin
				latch_nxt = 1'b0;
				speed_nxt = '0;
			end
			COLOR_BLUE: begin
				if (!latch_q) begin
					speed_nxt = SPEED_HALF;
				end
			end
			default: begin
				if (!latch_q) begin
					speed_nxt = '0;
				end
			end
		endcase
	end

	// Line state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			persist_q   <= '0;
			latch_q     <= 1'b0;
			speed_q     <= '0;
			res_valid_q <= 1'b0;
			color_q     <= COLOR_NONE;
		end else begin
			if (q_pop) begin
				persist_q   <= persist_nxt;
				latch_q     <= latch_nxt;
				speed_q     <= speed_nxt;
				color_q     <= color_nxt;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_color = color_q;
	assign res_speed = speed_q;

	// While the red latch is set the reduction is full.
	assert property (@(posedge clk) disable iff (!arst_n) latch_q |-> speed_q == SPEED_FULL)
		else $error("rlcc_back: latched without full reduction");

	// A green result always comes with no reduction and a clear latch.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && color_q == COLOR_GREEN) |-> (speed_q == '0 && !latch_q))
		else $error("rlcc_back: green result with reduction");

	// A red result always comes with the latch set.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && color_q == COLOR_RED) |-> latch_q)
		else $error("rlcc_back: red result without latch");

endmodule

/* sv/rgb565_line_color_classifier_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_line_color_classifier_core: RGB565 line color classifier
// Counts color hits over a camera line and reports the line class and the
// speed reduction once per line.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ stream at one per clock while s_tready is high;
// s_tlast marks the last pixel of a line, and one that reaches LINE_PIXELS
// pixels ends there anyway. Each line yields one result transfer on the m_
// stream from the output register. The front end counts hits, a line
// queue of QUEUE_DEPTH entries holds finished line totals, and the back end
// classifies them into an output register; s_tready drops only while that
// queue is full, which happens only when the m_ side stalls for lines.
// Thresholds are written through the cfg_ channel, which is always ready,
// and should be changed only while no line is in flight.
// ----------------------------------------------------------------------------
module rgb565_line_color_classifier_core
	import rlcc_pkg::*;
#(
	parameter int LINE_PIXELS = DEF_LINE_PIXELS,
	parameter int FULL_SPEED  = DEF_FULL_SPEED,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Pixel stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,  // [7:0] pixel_high_byte, [15:8] pixel_low_byte
	input  logic                  s_tlast,  // line_end
	// Result stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,  // [1:0] line_color, [12:2] speed_cut, rest zero
	// Configuration writes.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	pix_thr_t           pix_thr_q;
	line_thr_t          line_thr_q;
	logic               q_full, q_empty, q_push, q_pop;
	line_hits_t         q_in, q_out;
	color_t             res_color;
	logic [SPEED_W-1:0] res_speed;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_thr_q.red_min        <= RST_RED_MIN;
			pix_thr_q.red_green_max  <= RST_RED_GREEN_MAX;
			pix_thr_q.green_min      <= RST_GREEN_MIN;
			pix_thr_q.green_red_max  <= RST_GREEN_RED_MAX;
			pix_thr_q.blue_min       <= RST_BLUE_MIN;
			pix_thr_q.blue_red_max   <= RST_BLUE_RED_MAX;
			line_thr_q.line_hits_min <= RST_LINE_HITS_MIN;
			line_thr_q.persist_limit <= RST_PERSIST_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_RED_MIN:       pix_thr_q.red_min        <= cfg_data[RED_W-1:0];
				REG_RED_GREEN_MAX: pix_thr_q.red_green_max  <= cfg_data[GREEN_W-1:0];
				REG_GREEN_MIN:     pix_thr_q.green_min      <= cfg_data[GREEN_W-1:0];
				REG_GREEN_RED_MAX: pix_thr_q.green_red_max  <= cfg_data[RED_W-1:0];
				REG_BLUE_MIN:      pix_thr_q.blue_min       <= cfg_data[BLUE_W-1:0];
				REG_BLUE_RED_MAX:  pix_thr_q.blue_red_max   <= cfg_data[RED_W-1:0];
				REG_LINE_HITS_MIN: line_thr_q.line_hits_min <= cfg_data[HITS_W-1:0];
				REG_PERSIST_LIMIT: line_thr_q.persist_limit <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Pixel front end.
	rlcc_front #(
		.LINE_PIXELS(LINE_PIXELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.thr      (pix_thr_q),
		.pix_valid(s_tvalid),
		.pix_hi   (s_tdata[7:0]),
		.pix_lo   (s_tdata[15:8]),
		.pix_last (s_tlast),
		.pix_ready(s_tready),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	// Line queue.
	rlcc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_data (q_out)
	);

	// Line decision back end.
	rlcc_back #(
		.FULL_SPEED(FULL_SPEED)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.thr      (line_thr_q),
		.q_empty  (q_empty),
		.q_data   (q_out),
		.q_pop    (q_pop),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res_color(res_color),
		.res_speed(res_speed)
	);

	assign m_tdata = {3'b000, res_speed, res_color};

endmodule
